FILE: sv/ddi_pkg.sv
// Package: constants, tables and shared types for the dequantizing 8x8 IDCT.
package ddi_pkg;

  localparam int NumQtables = 4;
  localparam int TselW = 2;
  localparam int CoefW = 20;
  localparam int TmpW = 36;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROW,
    BK_COL,
    BK_CLEAR
  } bk_state_e;

  typedef struct packed {
    logic [5:0] nat_pos;
    logic signed [CoefW-1:0] coef;
    logic last;
  } coef_req_t;

  function automatic logic [5:0] zz_to_nat(input logic [5:0] z);
    logic [5:0] r;
    case (z)
      6'd0: r = 6'd0;    6'd1: r = 6'd1;    6'd2: r = 6'd8;    6'd3: r = 6'd16;
      6'd4: r = 6'd9;    6'd5: r = 6'd2;    6'd6: r = 6'd3;    6'd7: r = 6'd10;
      6'd8: r = 6'd17;   6'd9: r = 6'd24;   6'd10: r = 6'd32;  6'd11: r = 6'd25;
      6'd12: r = 6'd18;  6'd13: r = 6'd11;  6'd14: r = 6'd4;   6'd15: r = 6'd5;
      6'd16: r = 6'd12;  6'd17: r = 6'd19;  6'd18: r = 6'd26;  6'd19: r = 6'd33;
      6'd20: r = 6'd40;  6'd21: r = 6'd48;  6'd22: r = 6'd41;  6'd23: r = 6'd34;
      6'd24: r = 6'd27;  6'd25: r = 6'd20;  6'd26: r = 6'd13;  6'd27: r = 6'd6;
      6'd28: r = 6'd7;   6'd29: r = 6'd14;  6'd30: r = 6'd21;  6'd31: r = 6'd28;
      6'd32: r = 6'd35;  6'd33: r = 6'd42;  6'd34: r = 6'd49;  6'd35: r = 6'd56;
      6'd36: r = 6'd57;  6'd37: r = 6'd50;  6'd38: r = 6'd43;  6'd39: r = 6'd36;
      6'd40: r = 6'd29;  6'd41: r = 6'd22;  6'd42: r = 6'd15;  6'd43: r = 6'd23;
      6'd44: r = 6'd30;  6'd45: r = 6'd37;  6'd46: r = 6'd44;  6'd47: r = 6'd51;
      6'd48: r = 6'd58;  6'd49: r = 6'd59;  6'd50: r = 6'd52;  6'd51: r = 6'd45;
      6'd52: r = 6'd38;  6'd53: r = 6'd31;  6'd54: r = 6'd39;  6'd55: r = 6'd46;
      6'd56: r = 6'd53;  6'd57: r = 6'd60;  6'd58: r = 6'd61;  6'd59: r = 6'd54;
      6'd60: r = 6'd47;  6'd61: r = 6'd55;  6'd62: r = 6'd62;  default: r = 6'd63;
    endcase
    return r;
  endfunction

  function automatic logic signed [14:0] cos_q13(input logic [3:0] j);
    logic signed [14:0] r;
    case (j)
      4'd0: r = 15'sd8192;
      4'd1: r = 15'sd8035;
      4'd2: r = 15'sd7568;
      4'd3: r = 15'sd6811;
      4'd4: r = 15'sd5793;
      4'd5: r = 15'sd4551;
      4'd6: r = 15'sd3135;
      4'd7: r = 15'sd1598;
      default: r = 15'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [14:0] basis(input logic [2:0] k, input logic [2:0] x);
    logic [4:0] j;
    logic [4:0] m;
    logic signed [14:0] r;
    j = 5'((({2'b0, x} << 1) + 5'd1) * {2'b0, k});
    m = (j > 5'd16) ? 5'(6'd32 - {1'b0, j}) : j;
    if (k == 3'd0) r = 15'sd5793;
    else if (m > 5'd8) r = -cos_q13(4'(5'd16 - m));
    else r = cos_q13(m[3:0]);
    return r;
  endfunction

endpackage

FILE: sv/ddi_front.sv
// Front end: quantization table store, dequantization and zigzag reordering.
module ddi_front import ddi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic acc_i,
  input  logic mode_i,
  input  logic [TselW-1:0] table_select_i,
  input  logic [5:0] zigzag_position_i,
  input  logic [7:0] quant_value_i,
  input  logic signed [11:0] coeff_value_i,
  input  logic block_last_i,
  output logic req_valid_o,
  output coef_req_t req_o
);

  logic [7:0] qmem [NumQtables*64];
  logic [7:0] qrd_q;
  logic v_q, last_q, tok_q;
  logic [5:0] nat_q;
  logic signed [11:0] c_q;
  logic tsel_ok;

  assign tsel_ok = ({1'b0, table_select_i} < (TselW+1)'(NumQtables));

  always_ff @(posedge clk_i) begin
    if (acc_i && !mode_i && tsel_ok) begin
      qmem[{table_select_i, zigzag_position_i}] <= quant_value_i;
    end
    qrd_q <= qmem[{table_select_i, zigzag_position_i}];
    nat_q <= zz_to_nat(zigzag_position_i);
    c_q <= coeff_value_i;
    last_q <= block_last_i;
    tok_q <= tsel_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else v_q <= acc_i && mode_i;
  end

  assign req_valid_o = v_q;
  always_comb begin
    req_o.nat_pos = nat_q;
    req_o.last = last_q;
    req_o.coef = tok_q ? CoefW'(c_q * $signed({1'b0, qrd_q})) : '0;
  end

endmodule

FILE: sv/ddi_back.sv
// Back end: coefficient store and row/column IDCT with separate row and column MACs.
module ddi_back import ddi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  coef_req_t req_i,
  output logic busy_o,
  output logic sample_valid_o,
  output logic signed [10:0] sample_value_o,
  output logic [5:0] sample_index_o,
  output logic sample_last_o
);

  logic signed [CoefW-1:0] cmem [64];
  logic signed [TmpW-1:0] tmem [64];
  bk_state_e st_q, st_d;
  logic [8:0] cnt_q, cnt_d;
  logic signed [CoefW-1:0] crd_q;
  logic signed [TmpW-1:0] trd_q;
  logic signed [14:0] b_q;
  logic rd_v_q, rd_end_q, rd_row_q;
  logic [5:0] rd_idx_q;
  logic signed [TmpW-1:0] racc_q;
  logic signed [63:0] cacc_q;
  logic signed [63:0] cacc_n;
  logic signed [TmpW-1:0] racc_n;
  logic signed [63:0] rs;
  logic signed [35:0] r;
  logic [2:0] a_k, a_x, a_y;
  logic [5:0] crd_a, trd_a, clr_a;
  logic ov_q, ov_v_q, ov_l_q;
  logic signed [10:0] ov_s_q;
  logic [5:0] ov_i_q;

  assign a_k = cnt_q[2:0];
  assign a_x = cnt_q[5:3];
  assign a_y = cnt_q[8:6];
  assign crd_a = {a_y, a_k};
  assign trd_a = {a_k, a_x};
  assign clr_a = cnt_q[5:0];

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    case (st_q)
      BK_IDLE: if (req_valid_i && req_i.last) begin
        st_d = BK_ROW;
        cnt_d = '0;
      end
      BK_ROW: begin
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'd511) st_d = BK_COL;
      end
      BK_COL: begin
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'd511) st_d = BK_CLEAR;
      end
      BK_CLEAR: begin
        cnt_d = cnt_q + 9'd1;
        if (cnt_q[5:0] == 6'd63) st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // reset starts with a clearing pass over the coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_CLEAR;
      cnt_q <= '0;
      rd_v_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      rd_v_q <= (st_q == BK_ROW) || (st_q == BK_COL);
      ov_q <= rd_v_q && !rd_row_q && rd_end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_CLEAR) cmem[clr_a] <= '0;
    else if (req_valid_i) cmem[req_i.nat_pos] <= req_i.coef;
    crd_q <= cmem[crd_a];
    trd_q <= tmem[trd_a];
    b_q <= (st_q == BK_ROW) ? basis(a_k, a_x) : basis(a_k, a_y);
    rd_row_q <= (st_q == BK_ROW);
    rd_end_q <= (a_k == 3'd7);
    rd_idx_q <= (st_q == BK_ROW) ? {a_y, a_x} : {a_y, a_x};
    if (rd_v_q && rd_row_q) begin
      racc_q <= rd_end_q ? '0 : racc_n;
      if (rd_end_q) tmem[{rd_idx_q[5:3], rd_idx_q[2:0]}] <= racc_n;
    end
    if (rd_v_q && !rd_row_q) cacc_q <= rd_end_q ? '0 : cacc_n;
    if (rd_v_q && !rd_row_q && rd_end_q) begin
      ov_s_q <= (r > 36'sd1023) ? 11'sd1023 : (r < -36'sd1024) ? -11'sd1024 : r[10:0];
      ov_i_q <= rd_idx_q;
      ov_l_q <= (rd_idx_q == 6'd63);
    end
    if (st_q == BK_IDLE && !(req_valid_i && req_i.last)) begin
      racc_q <= '0;
      cacc_q <= '0;
    end
  end

  assign racc_n = racc_q + TmpW'(crd_q * b_q);
  assign cacc_n = cacc_q + 64'(trd_q * b_q);
  assign rs = cacc_n + 64'sd134217728;
  assign r = rs[63:28];

  assign ov_v_q = ov_q;
  assign busy_o = (st_q != BK_IDLE) || (req_valid_i && req_i.last) || rd_v_q || ov_q;
  assign sample_valid_o = ov_v_q;
  assign sample_value_o = ov_s_q;
  assign sample_index_o = ov_i_q;
  assign sample_last_o = ov_l_q;

endmodule

FILE: sv/dequant_dezigzag_idct8x8_top.sv
// Top level: dequantizing, de-zigzagging 8x8 inverse DCT.
// channel | ports                                            | handshake
// request | mode_i table_select_i zigzag_position_i data     | start && !busy
// sample  | sample_value_o sample_index_o sample_last_o     | sample_valid_o, one cycle
// A load or coefficient is accepted whenever busy is low. A last coefficient keeps busy
// high from its request through the row MACs, the column MACs and the store clearing,
// with separate row and column multiply-accumulates. After reset busy is high during
// the clearing pass. Samples cannot be stalled.
module dequant_dezigzag_idct8x8_top import ddi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic mode_i,
  input  logic [1:0] table_select_i,
  input  logic [5:0] zigzag_position_i,
  input  logic [7:0] quant_value_i,
  input  logic signed [11:0] coeff_value_i,
  input  logic block_last_i,
  output logic sample_valid_o,
  output logic signed [10:0] sample_value_o,
  output logic [5:0] sample_index_o,
  output logic sample_last_o
);

  logic acc, rq_v;
  coef_req_t rq;

  assign acc = start && !busy;

  ddi_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .mode_i, .table_select_i, .zigzag_position_i,
    .quant_value_i, .coeff_value_i, .block_last_i,
    .req_valid_o(rq_v), .req_o(rq)
  );

  ddi_back u_back (
    .clk_i, .rst_ni, .req_valid_i(rq_v), .req_i(rq), .busy_o(busy),
    .sample_valid_o, .sample_value_o, .sample_index_o, .sample_last_o
  );

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o && sample_last_o |-> sample_index_o == 6'd63) else $error("last idx");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> busy) else $error("sample while idle");
  a_no_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> !acc) else $error("accept during transform");

endmodule
